// ----- hdl/srts_pkg.sv -----
// srts_pkg: shared constants, types and the symbol lookup for the
// signed radix to symbols converter
// depends on nothing
package srts_pkg;

  localparam int DEF_MAX_SYMBOLS = 16;
  localparam int DEF_VALUE_BITS  = 32;
  localparam int DIV_STEP        = 8;

  localparam int SYM_W      = 8;
  localparam int RADIX_W    = 5;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_RADIX        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [SYM_W-1:0] SIGN_SYMBOL = 8'h2D;
  localparam logic [SYM_W-1:0] PLUS_SYMBOL = 8'h2B;

  typedef struct packed {
    logic load;
    logic step;
    logic digit_done;
    logic emit_inv;
    logic emit_sign;
    logic emit_digit;
    logic last;
  } srts_cmd_t;

  typedef struct packed {
    logic alpha_ok;
    logic neg;
    logic quot_zero;
  } srts_stat_t;

  function automatic logic [SYM_W-1:0] sym_at(input logic [3:0] idx,
                                              input logic [CFG_DATA_W-1:0] lo,
                                              input logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] word;
    word = idx[3] ? hi : lo;
    return word[{idx[2:0], 3'b000} +: SYM_W];
  endfunction

endpackage

// ----- hdl/srts_ctrl.sv -----
// srts_ctrl: sequencer for division rounds and symbol output
// depends on srts_pkg
module srts_ctrl
  import srts_pkg::*;
#(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  srts_stat_t stat,
  output srts_cmd_t  cmd
);

  localparam int DIV_CYC = (VALUE_BITS + DIV_STEP - 1) / DIV_STEP;
  localparam int SC_W    = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;
  localparam int CNT_W   = $clog2(VALUE_BITS + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_SIGN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [SC_W-1:0]  step_r, step_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!stat.alpha_ok) begin
            cmd.emit_inv = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            step_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (step_r == SC_W'(DIV_CYC - 1)) begin
          cmd.digit_done = 1'b1;
          cnt_nxt        = cnt_r + 1'b1;
          step_nxt       = '0;
          if (stat.quot_zero) begin
            state_nxt = stat.neg ? ST_SIGN : ST_EMIT;
          end
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_digit = 1'b1;
        cmd.last       = (cnt_r == CNT_W'(1));
        cnt_nxt        = cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- hdl/srts_dp.sv -----
// srts_dp: configuration registers, alphabet check, radix divider,
// digit stack and output register
// depends on srts_pkg
module srts_dp
  import srts_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic signed [VALUE_BITS-1:0] in_value,
  input  srts_cmd_t                    cmd,
  output srts_stat_t                   stat,
  output logic                         out_strobe,
  output logic [SYM_W-1:0]             out_symbol,
  output logic                         out_last,
  output logic                         out_invalid
);

  localparam int DIG_W  = $clog2(MAX_SYMBOLS);
  localparam int RAD_W  = DIG_W + 1;
  localparam int QW     = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
  localparam int STK_W  = VALUE_BITS * DIG_W;

  logic [RADIX_W-1:0]    radix_r;
  logic [CFG_DATA_W-1:0] sym_lo_r, sym_hi_r;

  logic [QW-1:0]         q_r, q_c;
  logic [DIG_W-1:0]      rem_r, rem_c;
  logic [RAD_W-1:0]      t_c, rad;
  logic                  neg_r;
  logic [STK_W-1:0]      stack_r;
  logic                  bad;
  logic [VALUE_BITS-1:0] v_u, mag;

  logic                  strobe_r, last_r, inv_r;
  logic [SYM_W-1:0]      symbol_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= '0;
      sym_lo_r <= '0;
      sym_hi_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RADIX:        radix_r  <= cfg_wdata[RADIX_W-1:0];
        REG_SYMBOLS_LOW:  sym_lo_r <= cfg_wdata;
        REG_SYMBOLS_HIGH: sym_hi_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // alphabet check: no sign or plus symbol and no two equal symbols among those in use
  always_comb begin
    bad = 1'b0;
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (RADIX_W'(i) < radix_r) begin
        if (sym_at(4'(i), sym_lo_r, sym_hi_r) == PLUS_SYMBOL ||
            sym_at(4'(i), sym_lo_r, sym_hi_r) == SIGN_SYMBOL) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (RADIX_W'(j) < radix_r &&
              sym_at(4'(i), sym_lo_r, sym_hi_r) == sym_at(4'(j), sym_lo_r, sym_hi_r)) begin
            bad = 1'b1;
          end
        end
      end
    end
  end

  assign stat.alpha_ok = !bad && (radix_r >= RADIX_W'(2)) &&
                         (radix_r <= RADIX_W'(MAX_SYMBOLS));
  assign stat.neg      = neg_r;

  assign v_u = in_value;
  assign mag = v_u[VALUE_BITS-1] ? VALUE_BITS'(~v_u + 1'b1) : v_u;
  assign rad = radix_r[RAD_W-1:0];

  // restoring division, DIV_STEP quotient bits a cycle
  always_comb begin
    q_c   = q_r;
    rem_c = rem_r;
    t_c   = '0;
    for (int s = 0; s < DIV_STEP; s++) begin
      t_c = {rem_c, q_c[QW-1]};
      q_c = {q_c[QW-2:0], 1'b0};
      if (t_c >= rad) begin
        t_c    = t_c - rad;
        q_c[0] = 1'b1;
      end
      rem_c = t_c[DIG_W-1:0];
    end
  end

  assign stat.quot_zero = (q_c == '0);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_r   <= QW'(mag);
      rem_r <= '0;
      neg_r <= v_u[VALUE_BITS-1];
    end else if (cmd.step) begin
      q_r   <= q_c;
      rem_r <= cmd.digit_done ? '0 : rem_c;
    end
    // digit stack, newest digit in the low bits
    if (cmd.step && cmd.digit_done) begin
      stack_r <= {stack_r[STK_W-DIG_W-1:0], rem_c};
    end else if (cmd.emit_digit) begin
      stack_r <= stack_r >> DIG_W;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.emit_inv | cmd.emit_sign | cmd.emit_digit;
    end
    if (cmd.emit_inv) begin
      symbol_r <= '0;
      last_r   <= 1'b1;
      inv_r    <= 1'b1;
    end else if (cmd.emit_sign) begin
      symbol_r <= SIGN_SYMBOL;
      last_r   <= 1'b0;
      inv_r    <= 1'b0;
    end else if (cmd.emit_digit) begin
      symbol_r <= sym_at(4'(stack_r[DIG_W-1:0]), sym_lo_r, sym_hi_r);
      last_r   <= cmd.last;
      inv_r    <= 1'b0;
    end
  end

  assign out_strobe  = strobe_r;
  assign out_symbol  = symbol_r;
  assign out_last    = last_r;
  assign out_invalid = inv_r;

endmodule

// ----- hdl/signed_radix_to_symbols.sv -----
// signed_radix_to_symbols: top level, signed value to symbol string in a
// configurable radix; instantiates srts_ctrl and srts_dp, uses srts_pkg
//
//   channel  ports                                         handshake
//   input    start, busy, in_value                         start & !busy
//   result   out_strobe, out_symbol, out_last, out_invalid out_strobe, one cycle
//   config   cfg_we, cfg_index, cfg_wdata                  cfg_we
//
// an item with D digits runs D division rounds in the divider
// (8 quotient bits a cycle), then one symbol per cycle, sign included
// invalid alphabet: one result the cycle after the transfer
// reset is synchronous; the result channel cannot stall
module signed_radix_to_symbols
  import srts_pkg::*;
#(
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_strobe,
  output logic [SYM_W-1:0]             out_symbol,
  output logic                         out_last,
  output logic                         out_invalid,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata
);

  srts_cmd_t  cmd;
  srts_stat_t stat;

  srts_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  srts_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_value    (in_value),
    .cmd         (cmd),
    .stat        (stat),
    .out_strobe  (out_strobe),
    .out_symbol  (out_symbol),
    .out_last    (out_last),
    .out_invalid (out_invalid)
  );

`ifndef SYNTHESIS
  // symbols of one value come in consecutive cycles
  no_gap_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside a symbol string");

  // a non-final symbol means the value is still in work
  busy_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |-> busy)
    else $error("non-final symbol while idle");

  // starting a conversion never coincides with a result
  load_a: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_strobe)
    else $error("result shown as conversion starts");

  // invalid result is a single zero symbol
  inv_a: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_invalid |-> out_last && out_symbol == '0)
    else $error("malformed invalid result");
`endif

endmodule

// ----- tb/sv/signed_radix_to_symbols_tb.sv -----
`timescale 1ns / 100ps
// signed_radix_to_symbols_tb: self-checking testbench for the signed radix to symbols
// converter; predicts every symbol transfer and compares it field by field
// depends on srts_pkg and signed_radix_to_symbols
module signed_radix_to_symbols_tb
  import srts_pkg::*;
();

  localparam int VALUE_W         = DEF_VALUE_BITS;
  localparam int SYMBOL_LIMIT    = DEF_MAX_SYMBOLS;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 30;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = ~VALUE_MIN;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             invalid;
  } sym_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic signed [VALUE_W-1:0]   in_value;
  logic                        out_strobe;
  logic [SYM_W-1:0]            out_symbol;
  logic                        out_last;
  logic                        out_invalid;
  logic                        cfg_we;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [CFG_DATA_W-1:0]       cfg_wdata;

  logic [RADIX_W-1:0]          cur_radix = '0;
  logic [2*CFG_DATA_W-1:0]     cur_alpha = '0;
  sym_result_t                 expected_syms [$];
  int                          error_count = 0;
  int                          cycle_count = 0;

  signed_radix_to_symbols #(
    .MAX_SYMBOLS(SYMBOL_LIMIT),
    .VALUE_BITS (VALUE_W)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_value   (in_value),
    .out_strobe (out_strobe),
    .out_symbol (out_symbol),
    .out_last   (out_last),
    .out_invalid(out_invalid),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("signed_radix_to_symbols verification failed");
      $finish;
    end
  end

  // result checker
  always @(posedge clk) begin
    sym_result_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      if (expected_syms.size() == 0) begin
        $error("unexpected transfer: symbol %0h last %0b invalid %0b",
               out_symbol, out_last, out_invalid);
        error_count++;
      end else begin
        want = expected_syms.pop_front();
        if (out_symbol !== want.symbol) begin
          $error("symbol: expected %0h, got %0h", want.symbol, out_symbol);
          error_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          error_count++;
        end
        if (out_invalid !== want.invalid) begin
          $error("invalid: expected %0b, got %0b", want.invalid, out_invalid);
          error_count++;
        end
      end
    end
  end

  function automatic logic [SYM_W-1:0] symbol_of(input logic [3:0] idx);
    return cur_alpha[{idx, 3'b000} +: SYM_W];
  endfunction

  function automatic bit alphabet_valid();
    logic [SYM_W-1:0] a;
    if (cur_radix < 2 || cur_radix > SYMBOL_LIMIT) return 1'b0;
    for (int i = 0; i < cur_radix; i++) begin
      a = symbol_of(4'(i));
      if (a == PLUS_SYMBOL || a == SIGN_SYMBOL) return 1'b0;
      for (int j = i + 1; j < cur_radix; j++)
        if (symbol_of(4'(j)) == a) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_symbols(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] mag;
    logic [3:0]         digits [$];
    if (!alphabet_valid()) begin
      expected_syms.push_back(sym_result_t'{'0, 1'b1, 1'b1});
      return;
    end
    mag = v;
    if (v[VALUE_W-1]) mag = ~mag + 1'b1;
    do begin
      digits.push_front(4'(mag % cur_radix));
      mag = mag / cur_radix;
    end while (mag != 0);
    if (v[VALUE_W-1]) expected_syms.push_back(sym_result_t'{SIGN_SYMBOL, 1'b0, 1'b0});
    foreach (digits[i])
      expected_syms.push_back(sym_result_t'{symbol_of(digits[i]),
                                            (i == digits.size() - 1), 1'b0});
  endfunction

  function automatic logic [2*CFG_DATA_W-1:0] ascii_alphabet();
    logic [2*CFG_DATA_W-1:0] alpha;
    for (int i = 0; i < 16; i++)
      alpha[i*8 +: 8] = (i < 10) ? 8'(8'h30 + i) : 8'(8'h41 + i - 10);
    return alpha;
  endfunction

  function automatic logic [2*CFG_DATA_W-1:0] distinct_alphabet(input int r);
    logic [2*CFG_DATA_W-1:0] alpha;
    logic [SYM_W-1:0]        b;
    bit                      used [256];
    alpha = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < r && i < 16; i++) begin
      do b = 8'($urandom_range(0, 255));
      while (used[b] || b == SIGN_SYMBOL || b == PLUS_SYMBOL);
      used[b] = 1'b1;
      alpha[i*8 +: 8] = b;
    end
    return alpha;
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return VALUE_MIN;
          1: return VALUE_MAX;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2: return $signed($urandom_range(0, 600)) - 300;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_RADIX:        cur_radix = data[RADIX_W-1:0];
      REG_SYMBOLS_LOW:  cur_alpha[CFG_DATA_W-1:0] = data;
      REG_SYMBOLS_HIGH: cur_alpha[2*CFG_DATA_W-1:CFG_DATA_W] = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic program_alphabet(input int r, input logic [2*CFG_DATA_W-1:0] alpha);
    logic [CFG_DATA_W-1:0] radix_word;
    radix_word = {$urandom, $urandom};
    radix_word[RADIX_W-1:0] = RADIX_W'(r);
    write_reg(REG_SYMBOLS_LOW, alpha[CFG_DATA_W-1:0]);
    write_reg(REG_SYMBOLS_HIGH, alpha[2*CFG_DATA_W-1:CFG_DATA_W]);
    write_reg(REG_RADIX, radix_word);
  endtask

  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    start    <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_symbols(v);
  endtask

  task automatic sender_gap();
    start <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk);
  endtask

  task automatic wait_for_symbols();
    start <= 1'b0;
    @(posedge clk);
    while (expected_syms.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic try_alphabet(input int r, input logic [2*CFG_DATA_W-1:0] alpha,
                              input logic signed [VALUE_W-1:0] v);
    wait_for_symbols();
    program_alphabet(r, alpha);
    send_value(v);
  endtask

  task automatic test_after_reset();
    send_value('0);
    send_value(-1);
  endtask

  task automatic test_decimal();
    wait_for_symbols();
    program_alphabet(10, ascii_alphabet());
    send_value('0);
    send_value(-1);
    send_value(9);
    send_value(10);
    send_value(VALUE_MAX);
    send_value(VALUE_MIN);
    send_value(-987);
  endtask

  task automatic test_binary_extremes();
    logic [2*CFG_DATA_W-1:0] alpha;
    alpha = '0;
    alpha[15:8] = 8'hFF;
    wait_for_symbols();
    program_alphabet(2, alpha);
    send_value(VALUE_MIN);
    send_value(VALUE_MAX);
    send_value('0);
  endtask

  task automatic test_hex_full_alphabet();
    logic [2*CFG_DATA_W-1:0] alpha;
    alpha = ascii_alphabet();
    alpha[7:0]     = 8'h00;
    alpha[127:120] = 8'hFF;
    wait_for_symbols();
    program_alphabet(16, alpha);
    send_value(VALUE_MIN);
    send_value(-1);
  endtask

  task automatic test_alphabet_checks();
    logic [2*CFG_DATA_W-1:0] alpha;
    try_alphabet(1, ascii_alphabet(), 5);
    try_alphabet(17, ascii_alphabet(), '0);
    try_alphabet(31, ascii_alphabet(), VALUE_MIN);
    alpha = ascii_alphabet();
    alpha[79:72] = alpha[7:0];
    try_alphabet(10, alpha, 123);
    alpha = ascii_alphabet();
    alpha[31:24] = PLUS_SYMBOL;
    try_alphabet(10, alpha, -5);
    alpha = ascii_alphabet();
    alpha[7:0] = SIGN_SYMBOL;
    try_alphabet(10, alpha, 7);
    alpha = ascii_alphabet();
    alpha[127:120] = SIGN_SYMBOL;
    try_alphabet(16, alpha, VALUE_MAX);
    // sign symbol beyond the radix is ignored
    alpha = ascii_alphabet();
    alpha[103:96] = SIGN_SYMBOL;
    try_alphabet(10, alpha, -12345);
    wait_for_symbols();
    write_reg(REG_UNUSED, '1);
    send_value(VALUE_MAX);
  endtask

  task automatic program_random_alphabet();
    int                      r;
    int                      kind;
    int                      a;
    int                      b;
    logic [2*CFG_DATA_W-1:0] alpha;
    kind = $urandom_range(0, 9);
    r = $urandom_range(2, SYMBOL_LIMIT);
    if (kind == 0) r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) : $urandom_range(17, 31);
    alpha = distinct_alphabet(r);
    if (kind == 1) begin
      a = $urandom_range(0, r - 1);
      b = (a + $urandom_range(1, r - 1)) % r;
      alpha[b*8 +: 8] = alpha[a*8 +: 8];
    end else if (kind == 2) begin
      a = $urandom_range(0, r - 1);
      alpha[a*8 +: 8] = $urandom_range(0, 1) ? SIGN_SYMBOL : PLUS_SYMBOL;
    end
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, {$urandom, $urandom});
    program_alphabet(r, alpha);
  endtask

  task automatic test_random_phases();
    int gap_odds;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_for_symbols();
      program_random_alphabet();
      gap_odds = (p == RANDOM_PHASES - 1) ? 0 : $urandom_range(0, 3);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(1, 4) <= gap_odds) sender_gap();
        if (p == 3 && n == ITEMS_PER_PHASE / 2) wait_for_symbols();
        send_value(random_value());
      end
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_value  <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_after_reset();
    test_decimal();
    test_binary_extremes();
    test_hex_full_alphabet();
    test_alphabet_checks();
    test_random_phases();
    wait_for_symbols();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_syms.size() == 0) begin
      $display("signed_radix_to_symbols verification clean");
    end else begin
      $display("signed_radix_to_symbols verification failed");
    end
    $finish;
  end

endmodule
